/* rtl/core/adaptive_guard_window_checker_macros.svh */
// ----------------------------------------------------------------------------
// adaptive guard window checker assertion macros
// shared property shapes for the checker, sampled on i_clk, off in reset
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_GUARD_WINDOW_CHECKER_MACROS_SVH
`define ADAPTIVE_GUARD_WINDOW_CHECKER_MACROS_SVH

// same-cycle implication
`define AGWC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("agwc assertion failed");

// next-cycle implication
`define AGWC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("agwc assertion failed");

`endif

/* rtl/core/agwc_pkg.sv */
// ----------------------------------------------------------------------------
// agwc_pkg
// widths, register codes, reset values and shared types of the guard checker
// ----------------------------------------------------------------------------
package agwc_pkg;

    // number of tracked streams
    localparam int unsigned STREAMS = 16;
    localparam int unsigned SLOT_W  = (STREAMS > 1) ? $clog2(STREAMS) : 1;

    // field widths
    localparam int unsigned IDX_W      = 4;
    localparam int unsigned TIME_W     = 48;
    localparam int unsigned INTERVAL_W = 40;
    localparam int unsigned GUARD_W    = 32;
    localparam int unsigned GAIN_W     = 16;
    localparam int unsigned FRAC_W     = 12;

    // split multiply of gain by the 48-bit error
    localparam int unsigned PART_W = TIME_W / 2;
    localparam int unsigned PROD_W = GAIN_W + PART_W;
    localparam int unsigned RAW_W  = TIME_W + GAIN_W - FRAC_W + 1;

    // stream memory word: expected time over last absolute error
    localparam int unsigned RAM_W = 2 * TIME_W;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = INTERVAL_W;

    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BASE      = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN      = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_MIN_GUARD = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_MAX_GUARD = CFG_IDX_W'(4);

    localparam logic [INTERVAL_W-1:0] RST_INTERVAL  = INTERVAL_W'(64'd30000000000);
    localparam logic [GUARD_W-1:0]    RST_BASE      = GUARD_W'(50000);
    localparam logic [GAIN_W-1:0]     RST_GAIN      = GAIN_W'(2048);
    localparam logic [GUARD_W-1:0]    RST_MIN_GUARD = GUARD_W'(10000);
    localparam logic [GUARD_W-1:0]    RST_MAX_GUARD = GUARD_W'(1000000);

    // live configuration
    typedef struct packed {
        logic [INTERVAL_W-1:0] interval;
        logic [GUARD_W-1:0]    base_guard;
        logic [GAIN_W-1:0]     gain;
        logic [GUARD_W-1:0]    min_guard;
        logic [GUARD_W-1:0]    max_guard;
    } t_cfg;

    // stream index to memory slot, folded modulo the stream count
    typedef logic [SLOT_W-1:0] t_slot;
    typedef t_slot t_slot_lut [2**IDX_W];

    function automatic t_slot_lut build_slot_lut();
        t_slot_lut lut;
        for (int i = 0; i < 2**IDX_W; i++) begin
            lut[i] = SLOT_W'(i % STREAMS);
        end
        return lut;
    endfunction

    localparam t_slot_lut SLOT_LUT = build_slot_lut();

endpackage

/* rtl/core/agwc_if.sv */
// ----------------------------------------------------------------------------
// agwc channel interfaces
// arrival, result and configuration channels with valid/ready handshake
// ----------------------------------------------------------------------------

// arrival word
interface agwc_arr_if;
    logic                          valid;
    logic                          ready;
    logic [agwc_pkg::IDX_W-1:0]    stream_index;
    logic [agwc_pkg::TIME_W-1:0]   arrival_time;

    modport source (output valid, output stream_index, output arrival_time, input ready);
    modport sink   (input valid, input stream_index, input arrival_time, output ready);
endinterface

// result word
interface agwc_res_if;
    logic                               valid;
    logic                               ready;
    logic                               accepted;
    logic signed [agwc_pkg::TIME_W-1:0] timing_error;
    logic [agwc_pkg::GUARD_W-1:0]       guard_used;

    modport source (output valid, output accepted, output timing_error, output guard_used,
                    input ready);
    modport sink   (input valid, input accepted, input timing_error, input guard_used,
                    output ready);
endinterface

// configuration write word
interface agwc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [agwc_pkg::CFG_IDX_W-1:0]    index;
    logic [agwc_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/agwc_ram.sv */
// ----------------------------------------------------------------------------
// agwc_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module agwc_ram #(
    parameter  int unsigned WIDTH  = 8,
    parameter  int unsigned DEPTH  = 16,
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/core/agwc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// agwc_cfg_regs
// configuration register file, written through the config channel
// ----------------------------------------------------------------------------
module agwc_cfg_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    agwc_cfg_if.sink       i_cfg,
    output agwc_pkg::t_cfg o_cfg
);

    agwc_pkg::t_cfg r_cfg;

    // always ready, each write is registered and visible the cycle after it is taken
    assign i_cfg.ready = 1'b1;

    // register writes, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.interval   <= agwc_pkg::RST_INTERVAL;
            r_cfg.base_guard <= agwc_pkg::RST_BASE;
            r_cfg.gain       <= agwc_pkg::RST_GAIN;
            r_cfg.min_guard  <= agwc_pkg::RST_MIN_GUARD;
            r_cfg.max_guard  <= agwc_pkg::RST_MAX_GUARD;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                agwc_pkg::REG_INTERVAL: begin
                    r_cfg.interval <= i_cfg.data[agwc_pkg::INTERVAL_W-1:0];
                end
                agwc_pkg::REG_BASE: begin
                    r_cfg.base_guard <= i_cfg.data[agwc_pkg::GUARD_W-1:0];
                end
                agwc_pkg::REG_GAIN: begin
                    r_cfg.gain <= i_cfg.data[agwc_pkg::GAIN_W-1:0];
                end
                agwc_pkg::REG_MIN_GUARD: begin
                    r_cfg.min_guard <= i_cfg.data[agwc_pkg::GUARD_W-1:0];
                end
                agwc_pkg::REG_MAX_GUARD: begin
                    r_cfg.max_guard <= i_cfg.data[agwc_pkg::GUARD_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/core/adaptive_guard_window_checker.sv */
// ----------------------------------------------------------------------------
// adaptive_guard_window_checker
// flow: an accepted arrival has its result word registered after the multiply,
//   sum, clamp and done states; one arrival is in flight, the next taken only
//   after the read, two-part gain multiply, guard add, clamp and write-back on
//   the per-stream memory, and not while a result waits on a stalled result word
// reset: stream valid flags and config registers cleared to defaults at once,
//   stream memory is not cleared and needs no clearing pass
// ----------------------------------------------------------------------------
module adaptive_guard_window_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    agwc_arr_if.sink   i_arr,
    agwc_res_if.source o_res,
    agwc_cfg_if.sink   i_cfg
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_MUL_LO = 6'b000010,
        S_MUL_HI = 6'b000100,
        S_SUM    = 6'b001000,
        S_CLAMP  = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    agwc_pkg::t_cfg cfg;

    logic                                in_accept;
    logic                                out_load;
    agwc_pkg::t_slot                     in_slot;
    logic [agwc_pkg::RAM_W-1:0]          ram_rd;
    logic [agwc_pkg::RAM_W-1:0]          ram_wr;
    logic [agwc_pkg::RAW_W-1:0]          clamp_lo;
    logic [agwc_pkg::GUARD_W-1:0]        clamp_g;

    logic [agwc_pkg::STREAMS-1:0]        r_valid;
    agwc_pkg::t_slot                     r_slot;
    logic                                r_first;
    logic [agwc_pkg::TIME_W-1:0]         r_arr;
    logic [agwc_pkg::TIME_W-1:0]         r_exp;
    logic [agwc_pkg::TIME_W-1:0]         r_last;
    logic [agwc_pkg::TIME_W-1:0]         r_err;
    logic [agwc_pkg::TIME_W-1:0]         r_mag;
    logic [agwc_pkg::TIME_W-1:0]         r_next_exp;
    logic [agwc_pkg::PROD_W-1:0]         r_prod_lo;
    logic [agwc_pkg::PROD_W-1:0]         r_prod_hi;
    logic [agwc_pkg::RAW_W-1:0]          r_guard_raw;
    logic [agwc_pkg::GUARD_W-1:0]        r_guard;

    logic                                r_out_valid;
    logic                                r_out_accepted;
    logic [agwc_pkg::TIME_W-1:0]         r_out_err;
    logic [agwc_pkg::GUARD_W-1:0]        r_out_guard;

    // configuration registers
    agwc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // handshake
    assign i_arr.ready = (r_state == S_IDLE) && i_rst_n;
    assign in_accept   = i_arr.valid && i_arr.ready;
    assign in_slot     = agwc_pkg::SLOT_LUT[i_arr.stream_index];
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || o_res.ready);

    // per-stream memory: expected time over last absolute error
    assign ram_wr = {r_next_exp, (r_first ? {agwc_pkg::TIME_W{1'b0}} : r_mag)};

    agwc_ram #(
        .WIDTH (agwc_pkg::RAM_W),
        .DEPTH (agwc_pkg::STREAMS)
    ) u_stream_ram (
        .i_clk     (i_clk),
        .i_wr_en   (out_load),
        .i_wr_addr (r_slot),
        .i_wr_data (ram_wr),
        .i_rd_en   (in_accept),
        .i_rd_addr (in_slot),
        .o_rd_data (ram_rd)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (in_accept) n_state = S_MUL_LO;
            S_MUL_LO: n_state = S_MUL_HI;
            S_MUL_HI: n_state = S_SUM;
            S_SUM:    n_state = S_CLAMP;
            S_CLAMP:  n_state = S_DONE;
            S_DONE:   if (out_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // stream valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (out_load) begin
            r_valid[r_slot] <= 1'b1;
        end
    end

    // guard clamp, max applied last
    always_comb begin
        clamp_lo = (r_guard_raw < agwc_pkg::RAW_W'(cfg.min_guard))
                 ? agwc_pkg::RAW_W'(cfg.min_guard) : r_guard_raw;
        clamp_g  = (clamp_lo > agwc_pkg::RAW_W'(cfg.max_guard))
                 ? cfg.max_guard : clamp_lo[agwc_pkg::GUARD_W-1:0];
    end

    // datapath steps
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    r_slot  <= in_slot;
                    r_arr   <= i_arr.arrival_time;
                    r_first <= !r_valid[in_slot];
                end
            end
            S_MUL_LO: begin
                r_exp     <= ram_rd[agwc_pkg::RAM_W-1:agwc_pkg::TIME_W];
                r_last    <= ram_rd[agwc_pkg::TIME_W-1:0];
                r_err     <= r_arr - ram_rd[agwc_pkg::RAM_W-1:agwc_pkg::TIME_W];
                r_prod_lo <= agwc_pkg::PROD_W'(cfg.gain)
                           * agwc_pkg::PROD_W'(ram_rd[agwc_pkg::PART_W-1:0]);
            end
            S_MUL_HI: begin
                r_prod_hi  <= agwc_pkg::PROD_W'(cfg.gain)
                            * agwc_pkg::PROD_W'(r_last[agwc_pkg::TIME_W-1:agwc_pkg::PART_W]);
                r_mag      <= r_err[agwc_pkg::TIME_W-1] ? (~r_err + 1'b1) : r_err;
                r_next_exp <= (r_first ? r_arr : r_exp)
                            + agwc_pkg::TIME_W'(cfg.interval);
            end
            S_SUM: begin
                // floor(gain * err / 2^12) from the two partial products, plus base
                r_guard_raw <= agwc_pkg::RAW_W'({r_prod_hi,
                                   {(agwc_pkg::PART_W - agwc_pkg::FRAC_W){1'b0}}})
                             + agwc_pkg::RAW_W'(r_prod_lo[agwc_pkg::PROD_W-1:agwc_pkg::FRAC_W])
                             + agwc_pkg::RAW_W'(cfg.base_guard);
            end
            S_CLAMP: begin
                r_guard <= clamp_g;
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            if (r_first) begin
                r_out_accepted <= 1'b1;
                r_out_err      <= '0;
                r_out_guard    <= cfg.base_guard;
            end else begin
                r_out_accepted <= (r_mag <= agwc_pkg::TIME_W'(r_guard));
                r_out_err      <= r_err;
                r_out_guard    <= r_guard;
            end
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.accepted     = r_out_accepted;
    assign o_res.timing_error = r_out_err;
    assign o_res.guard_used   = r_out_guard;

endmodule

/* rtl/core/agwc_chk.sv */
// ----------------------------------------------------------------------------
// agwc_chk
// port-level checks on the guard window checker, bound to the top level
// ----------------------------------------------------------------------------
`include "adaptive_guard_window_checker_macros.svh"

module agwc_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                i_in_ready,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic                                i_out_accepted,
    input logic [agwc_pkg::TIME_W-1:0]         i_out_timing_error,
    input logic [agwc_pkg::GUARD_W-1:0]        i_out_guard_used
);

    // one arrival in flight: busy right after taking a word
    `AGWC_ASSERT_NEXT(a_busy_after_accept, i_in_valid && i_in_ready, !i_in_ready)

    // a rejected arrival cannot have zero error
    `AGWC_ASSERT_IMPL(a_reject_nonzero, i_out_valid && !i_out_accepted, i_out_timing_error != '0)

    // a stalled result word holds
    `AGWC_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_accepted) && $stable(i_out_timing_error) && $stable(i_out_guard_used))

    // a new result word only appears while the block was busy
    `AGWC_ASSERT_IMPL(a_result_from_work, i_out_valid && !$past(i_out_valid), !$past(i_in_ready))

endmodule

bind adaptive_guard_window_checker agwc_chk u_agwc_chk (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_arr.valid),
    .i_in_ready         (i_arr.ready),
    .i_out_valid        (o_res.valid),
    .i_out_ready        (o_res.ready),
    .i_out_accepted     (o_res.accepted),
    .i_out_timing_error (o_res.timing_error),
    .i_out_guard_used   (o_res.guard_used)
);

/* tb/sv/adaptive_guard_window_checker_test.sv */
// ----------------------------------------------------------------------------
// adaptive_guard_window_checker_test
// self-checking bench: drives arrival words with random gaps and result
// backpressure, predicts accept flag, timing error and guard per stream, and
// compares every result word in order across several register settings
// ----------------------------------------------------------------------------
module adaptive_guard_window_checker_test;
    import agwc_pkg::*;

    // bench timing
    localparam int unsigned RESET_CYCLES  = 11;
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned QUIET_LIMIT   = 2000;
    localparam int unsigned REPORT_CAP    = 60;
    localparam int unsigned RAND_FIRST    = 200;
    localparam int unsigned RAND_PHASE    = 220;
    localparam int unsigned LAST_PHASE    = 6;

    // register indexes past the last real one
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(REG_MAX_GUARD + 1);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = '1;

    // error of exactly half the time range
    localparam logic [TIME_W-1:0] HALF_RANGE = {1'b1, {(TIME_W-1){1'b0}}};

    // one result word
    typedef struct packed {
        logic               accepted;
        logic [TIME_W-1:0]  timing_error;
        logic [GUARD_W-1:0] guard_used;
    } t_verdict;

    // where an arrival lands relative to the stream's expected time
    typedef enum {
        OFS_EXACT, OFS_NEAR, OFS_GUARD_HI, OFS_GUARD_LO, OFS_PAST_HI, OFS_PAST_LO,
        OFS_MOST_NEG, OFS_MOST_POS, OFS_ZERO, OFS_ALL_ONES, OFS_ANY
    } t_offset_kind;

    // per-stream window tracking and the queue of verdicts still owed
    class guard_verdict_board;
        t_cfg              cfg;
        bit                stream_on [STREAMS];
        logic [TIME_W-1:0] exp_time  [STREAMS];
        logic [TIME_W-1:0] last_err  [STREAMS];
        t_verdict          verdict_q [$];
        int unsigned       errors;

        function new();
            cfg = '{interval: RST_INTERVAL, base_guard: RST_BASE, gain: RST_GAIN,
                    min_guard: RST_MIN_GUARD, max_guard: RST_MAX_GUARD};
            foreach (stream_on[i]) begin
                stream_on[i] = 1'b0;
                exp_time[i]  = '0;
                last_err[i]  = '0;
            end
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_INTERVAL:  cfg.interval   = val[INTERVAL_W-1:0];
                REG_BASE:      cfg.base_guard = val[GUARD_W-1:0];
                REG_GAIN:      cfg.gain       = val[GAIN_W-1:0];
                REG_MIN_GUARD: cfg.min_guard  = val[GUARD_W-1:0];
                REG_MAX_GUARD: cfg.max_guard  = val[GUARD_W-1:0];
                default: ;
            endcase
        endfunction

        // base plus scaled last error, clamped up to min then down to max
        function logic [GUARD_W-1:0] guard_of(logic [TIME_W-1:0] prev_err);
            logic [TIME_W+GAIN_W-1:0] prod;
            logic [TIME_W+GAIN_W:0]   g;
            prod = cfg.gain * prev_err;
            g = cfg.base_guard + (prod >> FRAC_W);
            if (g < cfg.min_guard) g = cfg.min_guard;
            if (g > cfg.max_guard) g = cfg.max_guard;
            return g[GUARD_W-1:0];
        endfunction

        function void predict_verdict(logic [IDX_W-1:0] idx, logic [TIME_W-1:0] t);
            int unsigned        s;
            t_verdict           v;
            logic [TIME_W-1:0]  diff;
            logic [TIME_W-1:0]  mag;
            logic [GUARD_W-1:0] g;
            s = idx % STREAMS;
            if (!stream_on[s]) begin
                // first arrival opens the window
                stream_on[s]   = 1'b1;
                exp_time[s]    = t + cfg.interval;
                last_err[s]    = '0;
                v.accepted     = 1'b1;
                v.timing_error = '0;
                v.guard_used   = cfg.base_guard;
            end else begin
                g    = guard_of(last_err[s]);
                diff = t - exp_time[s];
                mag  = diff[TIME_W-1] ? -diff : diff;
                v.accepted     = (mag <= TIME_W'(g));
                v.timing_error = diff;
                v.guard_used   = g;
                last_err[s]    = mag;
                exp_time[s]    = exp_time[s] + cfg.interval;
            end
            verdict_q.push_back(v);
        endfunction

        function void report(string field, logic [63:0] want, logic [63:0] got);
            errors++;
            if (errors <= REPORT_CAP)
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
        endfunction

        function void check_verdict(t_verdict got);
            t_verdict want;
            if (verdict_q.size() == 0) begin
                errors++;
                if (errors <= REPORT_CAP)
                    $display("%0t: result word with no arrival pending: expected none, actual %0h",
                             $time, got);
                return;
            end
            want = verdict_q.pop_front();
            if (got.accepted !== want.accepted)
                report("accepted", want.accepted, got.accepted);
            if (got.timing_error !== want.timing_error)
                report("timing_error", want.timing_error, got.timing_error);
            if (got.guard_used !== want.guard_used)
                report("guard_used", want.guard_used, got.guard_used);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    agwc_arr_if arr_bus ();
    agwc_res_if res_bus ();
    agwc_cfg_if cfg_bus ();

    guard_verdict_board board;

    int unsigned arr_idle_pct  = 0;
    int unsigned res_stall_pct = 0;
    int unsigned rdy_hold      = 0;
    int unsigned quiet_cycles  = 0;

    adaptive_guard_window_checker i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_arr   (arr_bus),
        .o_res   (res_bus),
        .i_cfg   (cfg_bus)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result backpressure in bursts
    always @(negedge i_clk) begin
        if (rdy_hold > 0) begin
            res_bus.ready = 1'b0;
            rdy_hold--;
        end else if (i_rst_n && $urandom_range(99, 0) < res_stall_pct) begin
            res_bus.ready = 1'b0;
            rdy_hold = $urandom_range(11, 1) - 1;
        end else begin
            res_bus.ready = 1'b1;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && res_bus.valid && res_bus.ready)
            board.check_verdict('{accepted: res_bus.accepted,
                                  timing_error: res_bus.timing_error,
                                  guard_used: res_bus.guard_used});
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((arr_bus.valid && arr_bus.ready) || (res_bus.valid && res_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: watchdog: no transfer for %0d cycles", $time, quiet_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    // one register write, entered and left at a falling edge
    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] val);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data  = val;
        do @(posedge i_clk); while (!cfg_bus.ready);
        board.write_reg(idx, val);
        @(negedge i_clk);
        cfg_bus.valid = 1'b0;
    endtask

    // one arrival word with an optional idle burst ahead of it
    task automatic send_arrival(input logic [IDX_W-1:0] idx, input logic [TIME_W-1:0] t);
        if ($urandom_range(99, 0) < arr_idle_pct) begin
            arr_bus.valid = 1'b0;
            repeat ($urandom_range(11, 1)) @(negedge i_clk);
        end
        arr_bus.valid        = 1'b1;
        arr_bus.stream_index = idx;
        arr_bus.arrival_time = t;
        do @(posedge i_clk); while (!arr_bus.ready);
        board.predict_verdict(idx, t);
        @(negedge i_clk);
        arr_bus.valid = 1'b0;
    endtask

    // arrival time placed against the stream's current window
    function automatic logic [TIME_W-1:0] pick_arrival(int unsigned s, t_offset_kind kind);
        logic [TIME_W-1:0]  mid;
        logic [GUARD_W-1:0] g;
        logic [GUARD_W-1:0] step;
        mid = board.exp_time[s];
        g   = board.guard_of(board.last_err[s]);
        case (kind)
            OFS_EXACT:    return mid;
            OFS_NEAR: begin
                step = $urandom_range(g, 0);
                return $urandom_range(1, 0) ? mid + step : mid - step;
            end
            OFS_GUARD_HI: return mid + g;
            OFS_GUARD_LO: return mid - g;
            OFS_PAST_HI:  return mid + g + 1;
            OFS_PAST_LO:  return mid - g - 1;
            OFS_MOST_NEG: return mid + HALF_RANGE;
            OFS_MOST_POS: return mid + HALF_RANGE - 1;
            OFS_ZERO:     return '0;
            OFS_ALL_ONES: return '1;
            default:      return TIME_W'({$urandom, $urandom});
        endcase
    endfunction

    task automatic send_kind(input int unsigned s, input t_offset_kind kind);
        send_arrival(IDX_W'(s), pick_arrival(s, kind));
    endtask

    // mostly well-placed arrivals, some edge and wild ones
    task automatic send_random();
        int unsigned  s;
        int unsigned  roll;
        t_offset_kind kind;
        s    = $urandom_range(STREAMS - 1, 0);
        roll = $urandom_range(99, 0);
        if      (roll < 55) kind = OFS_NEAR;
        else if (roll < 63) kind = OFS_GUARD_HI;
        else if (roll < 68) kind = OFS_GUARD_LO;
        else if (roll < 73) kind = OFS_PAST_HI;
        else if (roll < 78) kind = OFS_PAST_LO;
        else if (roll < 82) kind = OFS_EXACT;
        else if (roll < 86) kind = OFS_MOST_NEG;
        else if (roll < 89) kind = OFS_MOST_POS;
        else if (roll < 92) kind = OFS_ZERO;
        else if (roll < 94) kind = OFS_ALL_ONES;
        else                kind = OFS_ANY;
        if (!board.stream_on[s])
            kind = OFS_ANY;
        send_kind(s, kind);
    endtask

    // wait for all owed results, then let the pipeline run dry
    task automatic settle();
        while (board.verdict_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // stimulus
    initial begin
        logic [INTERVAL_W-1:0] iv;
        logic [GUARD_W-1:0]    bg;
        logic [GAIN_W-1:0]     gn;
        logic [GUARD_W-1:0]    mn;
        logic [GUARD_W-1:0]    mx;

        board = new();
        i_rst_n              = 1'b0;
        arr_bus.valid        = 1'b0;
        arr_bus.stream_index = '0;
        arr_bus.arrival_time = '0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.index        = '0;
        cfg_bus.data         = '0;
        res_bus.ready        = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed words on reset settings
        arr_idle_pct  = 20;
        res_stall_pct = 20;
        send_kind(0, OFS_ZERO);
        send_kind(15, OFS_ALL_ONES);
        send_kind(5, OFS_ANY);
        send_kind(0, OFS_EXACT);
        send_kind(0, OFS_GUARD_HI);
        send_kind(0, OFS_PAST_LO);
        send_kind(0, OFS_GUARD_LO);
        send_kind(0, OFS_PAST_HI);
        send_kind(0, OFS_MOST_NEG);
        send_kind(0, OFS_MOST_POS);
        send_kind(0, OFS_EXACT);
        send_kind(15, OFS_EXACT);
        send_kind(15, OFS_GUARD_LO);
        send_kind(15, OFS_ALL_ONES);
        send_kind(15, OFS_ZERO);
        send_kind(5, OFS_NEAR);
        send_kind(5, OFS_PAST_HI);
        send_kind(10, OFS_ALL_ONES);
        send_kind(10, OFS_MOST_NEG);
        send_kind(10, OFS_MOST_NEG);
        repeat (RAND_FIRST) send_random();

        // register settings, extremes first
        for (int p = 1; p <= LAST_PHASE; p++) begin
            settle();
            case (p)
                1: begin
                    iv = '0; bg = '0; gn = '0; mn = '0; mx = '0;
                end
                2: begin
                    iv = '1; bg = '1; gn = '1; mn = '1; mx = '1;
                end
                3: begin
                    // min above max, max must win
                    iv = INTERVAL_W'({$urandom, $urandom});
                    bg = $urandom_range(1 << 20, 0);
                    gn = GAIN_W'($urandom);
                    mn = '1;
                    mx = $urandom_range(1 << 24, 0);
                end
                default: begin
                    iv = INTERVAL_W'({$urandom, $urandom});
                    bg = $urandom_range(1 << 20, 0);
                    gn = GAIN_W'($urandom);
                    mn = $urandom_range(1 << 16, 0);
                    mx = $urandom;
                end
            endcase
            program_reg(REG_INTERVAL, CFG_DATA_W'(iv));
            program_reg(REG_BASE, {(CFG_DATA_W-GUARD_W)'($urandom), bg});
            program_reg(REG_GAIN, {(CFG_DATA_W-GAIN_W)'($urandom), gn});
            program_reg(REG_MIN_GUARD, {(CFG_DATA_W-GUARD_W)'($urandom), mn});
            program_reg(REG_MAX_GUARD, {(CFG_DATA_W-GUARD_W)'($urandom), mx});
            program_reg(CFG_IDX_W'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)),
                        CFG_DATA_W'({$urandom, $urandom}));

            // no idling in the final stretch
            arr_idle_pct  = (p == LAST_PHASE) ? 0 : $urandom_range(50, 0);
            res_stall_pct = (p == LAST_PHASE) ? 0 : $urandom_range(50, 0);
            repeat (RAND_PHASE) send_random();
        end

        settle();
        if (board.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
